// File: design/dbf_pkg.sv
// Shared types, constants and threshold tables for the edge deblocking filter.
// Used by dbf_cfg, dbf_core and h264_style_edge_deblock_filter.
`default_nettype none
package dbf_pkg;

	localparam int QUANT_MAX_DEF       = 60;
	localparam int MAX_SAMPLE_BITS_DEF = 16;
	localparam int TAB_LAST            = 60;

	localparam int SAMPLE_W   = 16;
	localparam int QUANT_W    = 6;
	localparam int OFFSET_W   = 7;
	localparam int SBITS_W    = 5;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int SHIFT_W    = 4;
	localparam int TAB_W      = 8;

	localparam logic [QUANT_W-1:0] QUANT_RST = 6'd25;
	localparam logic [SBITS_W-1:0] SBITS_RST = 5'd8;
	localparam logic [SBITS_W-1:0] SBITS_MIN = 5'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUANT        = 2'd0,
		CFG_ALPHA_OFFSET = 2'd1,
		CFG_BETA_OFFSET  = 2'd2,
		CFG_SAMPLE_BITS  = 2'd3
	} cfg_idx_t;

	localparam logic [TAB_W-1:0] ALPHA_TAB [0:TAB_LAST] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 8'd4, 8'd5, 8'd6,
		8'd7, 8'd8, 8'd9, 8'd10, 8'd12, 8'd13, 8'd15, 8'd17, 8'd20, 8'd22,
		8'd25, 8'd28, 8'd32, 8'd36, 8'd40, 8'd45, 8'd50, 8'd56, 8'd63, 8'd71,
		8'd80, 8'd90, 8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182, 8'd203, 8'd226,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255
	};

	localparam logic [TAB_W-1:0] BETA_TAB [0:TAB_LAST] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd2, 8'd2, 8'd3,
		8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd6, 8'd6, 8'd7, 8'd7,
		8'd8, 8'd8, 8'd9, 8'd9, 8'd10, 8'd10, 8'd11, 8'd11, 8'd12, 8'd12,
		8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16, 8'd17, 8'd17,
		8'd18, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26,
		8'd27
	};

	localparam logic [TAB_W-1:0] C0_TAB [0:TAB_LAST] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4,
		8'd5, 8'd5, 8'd6, 8'd7, 8'd8, 8'd8, 8'd10, 8'd11, 8'd12, 8'd13,
		8'd15, 8'd17, 8'd19, 8'd21, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33,
		8'd35
	};

	typedef struct packed {
		logic [SAMPLE_W-1:0] alpha;
		logic [SAMPLE_W-1:0] beta;
		logic [SAMPLE_W-1:0] c0;
		logic [SAMPLE_W-1:0] unit;
		logic [SAMPLE_W-1:0] peak;
	} dbf_thr_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] p1;
		logic [SAMPLE_W-1:0] p0;
		logic [SAMPLE_W-1:0] q0;
		logic [SAMPLE_W-1:0] q1;
		logic                hit;
	} dbf_res_t;

endpackage
`default_nettype wire

// File: design/dbf_cfg.sv
// Configuration registers and registered threshold derivation (alpha, beta, c0, unit, peak).
// Depends on dbf_pkg.
`default_nettype none
module dbf_cfg #(
	parameter int QUANT_MAX       = dbf_pkg::QUANT_MAX_DEF,
	parameter int MAX_SAMPLE_BITS = dbf_pkg::MAX_SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dbf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [dbf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output dbf_pkg::dbf_thr_t                     thr
);

	localparam logic [dbf_pkg::QUANT_W-1:0] QMAX   = dbf_pkg::QUANT_W'(QUANT_MAX);
	localparam logic [dbf_pkg::SBITS_W-1:0] SB_MAX = dbf_pkg::SBITS_W'(MAX_SAMPLE_BITS);

	logic        [dbf_pkg::QUANT_W-1:0]  quant_q;
	logic signed [dbf_pkg::OFFSET_W-1:0] alpha_off_q;
	logic signed [dbf_pkg::OFFSET_W-1:0] beta_off_q;
	logic        [dbf_pkg::SBITS_W-1:0]  sbits_q;

	logic [dbf_pkg::QUANT_W-1:0]  q_sat;
	logic [dbf_pkg::QUANT_W-1:0]  ia;
	logic [dbf_pkg::QUANT_W-1:0]  ib;
	logic [dbf_pkg::SBITS_W-1:0]  bits;
	logic [dbf_pkg::SBITS_W-1:0]  shift_full;
	logic [dbf_pkg::SHIFT_W-1:0]  shift;
	logic [dbf_pkg::SAMPLE_W:0]   peak_full;
	dbf_pkg::dbf_thr_t            thr_d;
	dbf_pkg::dbf_thr_t            thr_q;

	function automatic logic [dbf_pkg::QUANT_W-1:0] tab_idx(
		input logic [dbf_pkg::QUANT_W-1:0]         q,
		input logic signed [dbf_pkg::OFFSET_W-1:0] off
	);
		logic signed [dbf_pkg::QUANT_W+1:0] sum;
		sum = $signed({2'b00, q}) + $signed({off[dbf_pkg::OFFSET_W-1], off});
		if (sum < 0)
			tab_idx = '0;
		else if (sum > $signed({2'b00, QMAX}))
			tab_idx = QMAX;
		else
			tab_idx = sum[dbf_pkg::QUANT_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_q     <= dbf_pkg::QUANT_RST;
			alpha_off_q <= '0;
			beta_off_q  <= '0;
			sbits_q     <= dbf_pkg::SBITS_RST;
		end else if (cfg_we) begin
			case (dbf_pkg::cfg_idx_t'(cfg_idx))
				dbf_pkg::CFG_QUANT:        quant_q     <= cfg_wdata[dbf_pkg::QUANT_W-1:0];
				dbf_pkg::CFG_ALPHA_OFFSET: alpha_off_q <= cfg_wdata[dbf_pkg::OFFSET_W-1:0];
				dbf_pkg::CFG_BETA_OFFSET:  beta_off_q  <= cfg_wdata[dbf_pkg::OFFSET_W-1:0];
				dbf_pkg::CFG_SAMPLE_BITS:  sbits_q     <= cfg_wdata[dbf_pkg::SBITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		q_sat = (quant_q > QMAX) ? QMAX : quant_q;
		ia    = tab_idx(q_sat, alpha_off_q);
		ib    = tab_idx(q_sat, beta_off_q);
		if (sbits_q < dbf_pkg::SBITS_MIN)
			bits = dbf_pkg::SBITS_MIN;
		else if (sbits_q > SB_MAX)
			bits = SB_MAX;
		else
			bits = sbits_q;
		shift_full  = bits - dbf_pkg::SBITS_MIN;
		shift       = shift_full[dbf_pkg::SHIFT_W-1:0];
		peak_full   = ((dbf_pkg::SAMPLE_W+1)'(1) << bits) - (dbf_pkg::SAMPLE_W+1)'(1);
		thr_d.alpha = dbf_pkg::SAMPLE_W'(dbf_pkg::ALPHA_TAB[ia]) << shift;
		thr_d.beta  = dbf_pkg::SAMPLE_W'(dbf_pkg::BETA_TAB[ib]) << shift;
		thr_d.c0    = dbf_pkg::SAMPLE_W'(dbf_pkg::C0_TAB[ia]) << shift;
		thr_d.unit  = dbf_pkg::SAMPLE_W'(1) << shift;
		thr_d.peak  = peak_full[dbf_pkg::SAMPLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		thr_q <= thr_d;
	end

	assign thr = thr_q;

endmodule
`default_nettype wire

// File: design/dbf_core.sv
// Edge filter datapath: threshold test, delta clipping and sample updates for one line.
// Depends on dbf_pkg.
`default_nettype none
module dbf_core (
	input  wire dbf_pkg::dbf_thr_t             thr,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]  p2,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]  p1,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]  p0,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]  q0,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]  q1,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]  q2,
	output dbf_pkg::dbf_res_t                  res
);

	localparam int W  = dbf_pkg::SAMPLE_W;
	localparam int XW = W + 4;

	logic                 test;
	logic                 ap_ok;
	logic                 aq_ok;
	logic [W:0]           c;
	logic [W:0]           avg_sum;
	logic [W-1:0]         avg;
	logic signed [XW-1:0] cs;
	logic signed [XW-1:0] c0s;
	logic signed [XW-1:0] d_raw;
	logic signed [XW-1:0] d_sh;
	logic signed [XW-1:0] delta;
	logic signed [XW-1:0] np0_raw;
	logic signed [XW-1:0] nq0_raw;
	logic signed [XW-1:0] tp_raw;
	logic signed [XW-1:0] tq_raw;
	logic signed [XW-1:0] tp;
	logic signed [XW-1:0] tq;
	logic signed [XW-1:0] peak_s;

	function automatic logic [W-1:0] absdiff(input logic [W-1:0] a, input logic [W-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic signed [XW-1:0] clip(
		input logic signed [XW-1:0] x,
		input logic signed [XW-1:0] lim
	);
		if (x > lim)
			clip = lim;
		else if (x < -lim)
			clip = -lim;
		else
			clip = x;
	endfunction

	function automatic logic [W-1:0] sat(
		input logic signed [XW-1:0] x,
		input logic signed [XW-1:0] pk
	);
		if (x < 0)
			sat = '0;
		else if (x > pk)
			sat = pk[W-1:0];
		else
			sat = x[W-1:0];
	endfunction

	always_comb begin
		test  = (absdiff(p0, q0) < thr.alpha) && (absdiff(p1, p0) < thr.beta)
			&& (absdiff(q1, q0) < thr.beta);
		ap_ok = absdiff(p2, p0) < thr.beta;
		aq_ok = absdiff(q2, q0) < thr.beta;
		c     = {1'b0, thr.c0} + (ap_ok ? {1'b0, thr.unit} : '0)
			+ (aq_ok ? {1'b0, thr.unit} : '0);
		cs     = $signed({3'b000, c});
		c0s    = $signed({4'h0, thr.c0});
		peak_s = $signed({4'h0, thr.peak});

		d_raw = $signed({2'b00, q0, 2'b00} - {2'b00, p0, 2'b00} + {4'h0, p1} - {4'h0, q1}
			+ XW'(4));
		d_sh  = d_raw >>> 3;
		delta = clip(d_sh, cs);

		np0_raw = $signed({4'h0, p0}) + delta;
		nq0_raw = $signed({4'h0, q0}) - delta;

		avg_sum = {1'b0, p0} + {1'b0, q0} + (W+1)'(1);
		avg     = avg_sum[W:1];
		tp_raw  = $signed({4'h0, p2} + {4'h0, avg} - {3'b000, p1, 1'b0});
		tq_raw  = $signed({4'h0, q2} + {4'h0, avg} - {3'b000, q1, 1'b0});
		tp      = clip(tp_raw >>> 1, c0s);
		tq      = clip(tq_raw >>> 1, c0s);

		res.hit = test;
		res.p0  = test ? sat(np0_raw, peak_s) : p0;
		res.q0  = test ? sat(nq0_raw, peak_s) : q0;
		res.p1  = (test && ap_ok) ? (p1 + tp[W-1:0]) : p1;
		res.q1  = (test && aq_ok) ? (q1 + tq[W-1:0]) : q1;
	end

endmodule
`default_nettype wire

// File: design/h264_style_edge_deblock_filter.sv
// Top level of the normal-strength edge deblocking filter: handshakes and pipeline registers.
// Depends on dbf_pkg, dbf_cfg and dbf_core.
//
// One line of six samples across a block edge enters per transaction and yields one
// result transaction with filtered p1, p0, q0, q1 and a flag telling whether the edge
// passed the threshold test. The block takes a new line every cycle unless a result held
// back by a low out_ready fills the result register. A line passes through the input
// register, then the filter logic into the result register, from which it leaves when
// out_ready is high. The result register lets a new line enter while an earlier result still
// waits on out_ready. Configuration writes take effect for lines accepted from the next
// cycle on; write only while no line is in flight.
`default_nettype none
module h264_style_edge_deblock_filter #(
	parameter int QUANT_MAX       = dbf_pkg::QUANT_MAX_DEF,
	parameter int MAX_SAMPLE_BITS = dbf_pkg::MAX_SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dbf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [dbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]   p2_in,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]   p1_in,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]   p0_in,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]   q0_in,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]   q1_in,
	input  wire logic [dbf_pkg::SAMPLE_W-1:0]   q2_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [dbf_pkg::SAMPLE_W-1:0]        p1_out,
	output logic [dbf_pkg::SAMPLE_W-1:0]        p0_out,
	output logic [dbf_pkg::SAMPLE_W-1:0]        q0_out,
	output logic [dbf_pkg::SAMPLE_W-1:0]        q1_out,
	output logic                                filtered
);

	dbf_pkg::dbf_thr_t thr;
	dbf_pkg::dbf_res_t res;
	dbf_pkg::dbf_res_t res_s2;

	logic                          valid_s1;
	logic                          valid_s2;
	logic                          s2_load;
	logic [dbf_pkg::SAMPLE_W-1:0]  p2_s1;
	logic [dbf_pkg::SAMPLE_W-1:0]  p1_s1;
	logic [dbf_pkg::SAMPLE_W-1:0]  p0_s1;
	logic [dbf_pkg::SAMPLE_W-1:0]  q0_s1;
	logic [dbf_pkg::SAMPLE_W-1:0]  q1_s1;
	logic [dbf_pkg::SAMPLE_W-1:0]  q2_s1;

	dbf_cfg #(
		.QUANT_MAX       (QUANT_MAX),
		.MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.thr       (thr)
	);

	dbf_core u_core (
		.thr (thr),
		.p2  (p2_s1),
		.p1  (p1_s1),
		.p0  (p0_s1),
		.q0  (q0_s1),
		.q1  (q1_s1),
		.q2  (q2_s1),
		.res (res)
	);

	assign s2_load  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!valid_s2 || out_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p2_s1 <= p2_in;
			p1_s1 <= p1_in;
			p0_s1 <= p0_in;
			q0_s1 <= q0_in;
			q1_s1 <= q1_in;
			q2_s1 <= q2_in;
		end
		if (s2_load)
			res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign p1_out    = res_s2.p1;
	assign p0_out    = res_s2.p0;
	assign q0_out    = res_s2.q0;
	assign q1_out    = res_s2.q1;
	assign filtered  = res_s2.hit;

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but in_ready low");

	a_take_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted transaction lost from input stage");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load |=> out_valid && (filtered == $past(res.hit)))
		else $error("result stage failed to capture transaction");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load && !res.hit |=> (p1_out == $past(p1_s1)) && (p0_out == $past(p0_s1))
			&& (q0_out == $past(q0_s1)) && (q1_out == $past(q1_s1)))
		else $error("unfiltered line changed samples");
`endif

endmodule
`default_nettype wire
